/* rtl/vntc_pkg.sv */
// vntc_pkg: shared types, constants and arithmetic helpers for the value
// noise terrain classifier. No dependencies.
package vntc_pkg;

	// hash constants
	localparam logic [31:0] HASH_PX  = 32'd374761393;
	localparam logic [31:0] HASH_PY  = 32'd668265263;
	localparam logic [31:0] HASH_MIX = 32'h9E3779B9;
	localparam logic [31:0] HASH_MUL = 32'd1274126177;

	// fixed point widths
	localparam int unsigned HASH_W   = 24;    // hash value, full scale 2^24-1
	localparam int unsigned FRAC_W   = 16;    // Q.16 fraction
	localparam int unsigned SMOOTH_W = 17;    // smoothstep weight, 0 .. 65536
	localparam int unsigned HEIGHT_W = 17;    // Q1.16 height
	localparam int unsigned COORD_W  = 10;
	localparam int unsigned FREQ_W   = 24;
	localparam int unsigned XB_W     = COORD_W + FREQ_W;
	localparam int unsigned PX_W     = 64;    // sample point after octave shift
	localparam int unsigned MAP_SIZE = 1024;

	localparam logic [17:0]         SMOOTH_K   = 18'd196608;
	localparam logic [HEIGHT_W-1:0] HEIGHT_ONE = 17'd65536;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_SEED   = 3'd0,
		CFG_FREQ   = 3'd1,
		CFG_OCT    = 3'd2,
		CFG_WATER  = 3'd3,
		CFG_GRASS  = 3'd4,
		CFG_FOREST = 3'd5,
		CFG_PEAK   = 3'd6
	} cfg_idx_t;

	typedef enum logic [2:0] {
		TERR_WATER    = 3'd0,
		TERR_GRASS    = 3'd1,
		TERR_FOREST   = 3'd2,
		TERR_DESERT   = 3'd3,
		TERR_MOUNTAIN = 3'd4
	} terrain_t;

	// (t*t) >> 16
	function automatic logic [FRAC_W-1:0] smooth_sq(input logic [FRAC_W-1:0] t);
		logic [2*FRAC_W-1:0] p;
		p = (2*FRAC_W)'(t) * (2*FRAC_W)'(t);
		return p[2*FRAC_W-1:FRAC_W];
	endfunction

	// (t2 * (3 - 2t)) >> 16
	function automatic logic [SMOOTH_W-1:0] smooth_fin(input logic [FRAC_W-1:0] t,
			input logic [FRAC_W-1:0] t2);
		logic [17:0] k;
		logic [33:0] p;
		k = SMOOTH_K - {1'b0, t, 1'b0};
		p = 34'(t2) * 34'(k);
		return p[FRAC_W+SMOOTH_W-1:FRAC_W];
	endfunction

	// (|b-a| * s) >> 16
	function automatic logic [HASH_W-1:0] lerp_mul(input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] b, input logic [SMOOTH_W-1:0] s);
		logic [HASH_W-1:0] d;
		logic [HASH_W+SMOOTH_W-1:0] p;
		d = (b >= a) ? (b - a) : (a - b);
		p = (HASH_W+SMOOTH_W)'(d) * (HASH_W+SMOOTH_W)'(s);
		return p[HASH_W+FRAC_W-1:FRAC_W];
	endfunction

	// step from a toward b, truncating toward a
	function automatic logic [HASH_W-1:0] lerp_add(input logic [HASH_W-1:0] a,
			input logic [HASH_W-1:0] pd, input logic up);
		return up ? (a + pd) : (a - pd);
	endfunction

endpackage

/* rtl/vntc_hash.sv */
// vntc_hash: three-stage pipelined seeded lattice hash, 24-bit result.
// Depends on vntc_pkg.
module vntc_hash (
	input  logic                        clk,
	input  logic                        en,
	input  logic [31:0]                 seed,
	input  logic [31:0]                 i,
	input  logic [31:0]                 j,
	output logic [vntc_pkg::HASH_W-1:0] v
);
	import vntc_pkg::*;

	logic [31:0] mi_s1, mj_s1, h2_s2, m_s3;
	logic [31:0] h;
	logic [31:0] m_fin;

	// stage 1: lattice products
	always_ff @(posedge clk) begin
		if (en) begin
			mi_s1 <= i * HASH_PX;
			mj_s1 <= j * HASH_PY;
		end
	end

	// stage 2: seed mix
	assign h = mi_s1 + mj_s1;
	always_ff @(posedge clk) begin
		if (en) h2_s2 <= h ^ (seed + HASH_MIX + (h << 6) + (h >> 2));
	end

	// stage 3: avalanche multiply
	always_ff @(posedge clk) begin
		if (en) m_s3 <= (h2_s2 ^ (h2_s2 >> 13)) * HASH_MUL;
	end

	assign m_fin = m_s3 ^ (m_s3 >> 16);
	assign v     = m_fin[HASH_W-1:0];

endmodule

/* rtl/vntc_lane.sv */
// vntc_lane: one noise octave, eight register stages from scaled coordinate
// to blended noise value. Depends on vntc_pkg and vntc_hash.
module vntc_lane #(
	parameter int unsigned OCT = 0
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [31:0]                 seed,
	input  logic [vntc_pkg::XB_W-1:0]   xb,
	input  logic [vntc_pkg::XB_W-1:0]   yb,
	output logic [vntc_pkg::HASH_W-1:0] n
);
	import vntc_pkg::*;

	logic [PX_W-1:0]     px, py;
	logic [31:0]         ix, iy;
	logic [HASH_W-1:0]   h00, h10, h01, h11;
	logic [FRAC_W-1:0]   tx_s3, ty_s3, tx2_s3, ty2_s3;
	logic [SMOOTH_W-1:0] sx_s4, sx_s5, sx_s6;
	logic [SMOOTH_W-1:0] sy_s4, sy_s5, sy_s6, sy_s7, sy_s8;
	logic [HASH_W-1:0]   v00_s6, v10_s6, v01_s6, v11_s6;
	logic [HASH_W-1:0]   a0_s7, a1_s7, pd0_s7, pd1_s7;
	logic                up0_s7, up1_s7;
	logic [HASH_W-1:0]   r0_s8, r1_s8;
	logic [HASH_W-1:0]   rb_s9, pd_s9;
	logic                up_s9;
	logic [HASH_W-1:0]   n_s10;

	// octave frequency is base << OCT
	assign px = PX_W'(xb) << OCT;
	assign py = PX_W'(yb) << OCT;
	assign ix = px[FRAC_W+31:FRAC_W];
	assign iy = py[FRAC_W+31:FRAC_W];

	// corner hashes, stages 3..5
	vntc_hash u_h00 (.clk(clk), .en(en), .seed(seed), .i(ix),         .j(iy),         .v(h00));
	vntc_hash u_h10 (.clk(clk), .en(en), .seed(seed), .i(ix + 32'd1), .j(iy),         .v(h10));
	vntc_hash u_h01 (.clk(clk), .en(en), .seed(seed), .i(ix),         .j(iy + 32'd1), .v(h01));
	vntc_hash u_h11 (.clk(clk), .en(en), .seed(seed), .i(ix + 32'd1), .j(iy + 32'd1), .v(h11));

	// smoothstep weights, carried until used
	always_ff @(posedge clk) begin
		if (en) begin
			tx_s3  <= px[FRAC_W-1:0];
			ty_s3  <= py[FRAC_W-1:0];
			tx2_s3 <= smooth_sq(px[FRAC_W-1:0]);
			ty2_s3 <= smooth_sq(py[FRAC_W-1:0]);
			sx_s4  <= smooth_fin(tx_s3, tx2_s3);
			sy_s4  <= smooth_fin(ty_s3, ty2_s3);
			sx_s5  <= sx_s4;
			sx_s6  <= sx_s5;
			sy_s5  <= sy_s4;
			sy_s6  <= sy_s5;
			sy_s7  <= sy_s6;
			sy_s8  <= sy_s7;
		end
	end

	// horizontal blends, then vertical blend
	always_ff @(posedge clk) begin
		if (en) begin
			v00_s6 <= h00;
			v10_s6 <= h10;
			v01_s6 <= h01;
			v11_s6 <= h11;
			a0_s7  <= v00_s6;
			a1_s7  <= v01_s6;
			up0_s7 <= v10_s6 >= v00_s6;
			up1_s7 <= v11_s6 >= v01_s6;
			pd0_s7 <= lerp_mul(v00_s6, v10_s6, sx_s6);
			pd1_s7 <= lerp_mul(v01_s6, v11_s6, sx_s6);
			r0_s8  <= lerp_add(a0_s7, pd0_s7, up0_s7);
			r1_s8  <= lerp_add(a1_s7, pd1_s7, up1_s7);
			rb_s9  <= r0_s8;
			up_s9  <= r1_s8 >= r0_s8;
			pd_s9  <= lerp_mul(r0_s8, r1_s8, sy_s8);
			n_s10  <= lerp_add(rb_s9, pd_s9, up_s9);
		end
	end

	assign n = n_s10;

endmodule

/* rtl/vntc_div.sv */
// vntc_div: restoring divider, one quotient bit per stage, 17 stages.
// Gives floor(num * 65536 / den) for num <= den. Depends on vntc_pkg.
module vntc_div #(
	parameter int unsigned SW = 32
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [SW-1:0]                 num,
	input  logic [SW-1:0]                 den,
	output logic [vntc_pkg::HEIGHT_W-1:0] quo
);
	import vntc_pkg::*;

	localparam int unsigned NB = HEIGHT_W;

	logic [SW-1:0] rem_s [NB];
	logic [NB-1:0] q_s   [NB];

	// integer bit
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= (num >= den) ? (num - den) : num;
			q_s[0]   <= NB'(num >= den);
		end
	end

	// fraction bits
	for (genvar b = 1; b < NB; b++) begin : g_bit
		logic [SW:0] r2;
		logic        ge;
		assign r2 = {rem_s[b-1], 1'b0};
		assign ge = r2 >= {1'b0, den};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[b] <= ge ? SW'(r2 - {1'b0, den}) : SW'(r2);
				q_s[b]   <= {q_s[b-1][NB-2:0], ge};
			end
		end
	end

	assign quo = q_s[NB-1];

endmodule

/* rtl/value_noise_terrain_classifier_unit.sv */
// Fractal value noise height and terrain classifier, top level.
// Each beat passes the coordinate registers, octave lanes, Horner stages, divider and output register.
// Throughput: one beat per cycle; the whole pipeline advances when the output
// register is empty or being taken.
// Reset (arst_n low) clears all valid bits and loads the default configuration.
// Depends on vntc_pkg, vntc_lane, vntc_hash, vntc_div.
module value_noise_terrain_classifier_unit #(
	parameter int unsigned MAX_OCTAVES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [9:0] x_coord, [19:10] y_coord
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,    // [16:0] height, [19:17] terrain
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [31:0] wr_data
);
	import vntc_pkg::*;

	localparam int unsigned OCT_W    = $clog2(MAX_OCTAVES + 1);
	localparam int unsigned SUM_W    = HASH_W + MAX_OCTAVES;
	localparam int unsigned HASH_LAT = 3;
	localparam int unsigned LANE_LAT = 8;
	localparam int unsigned DIV_LAT  = HEIGHT_W;
	localparam int unsigned SUM_STG  = 2 + LANE_LAT + MAX_OCTAVES;
	localparam int unsigned DIV_STG  = SUM_STG + DIV_LAT;
	localparam int unsigned SEL_LEN  = DIV_STG - (1 + HASH_LAT);

	// configuration registers
	logic [31:0]         noise_seed_q;
	logic [FREQ_W-1:0]   base_frequency_q;
	logic [3:0]          octave_count_q;
	logic [HEIGHT_W-1:0] water_level_q, grass_level_q, forest_level_q, peak_level_q;
	logic [OCT_W-1:0]    k_q;
	logic [SUM_W-1:0]    den_q;

	logic                en;
	logic                vld_s [1:DIV_STG];
	logic [COORD_W-1:0]  x_s1, y_s1;
	logic [XB_W-1:0]     xb_s2, yb_s2;
	logic [HASH_W-1:0]   lane_n [MAX_OCTAVES];
	logic [SUM_W-1:0]    acc_s  [1:MAX_OCTAVES];
	logic [HASH_W-1:0]   nrow_s [MAX_OCTAVES][MAX_OCTAVES];
	logic [HASH_W-1:0]   sel_v;
	logic                sel_s [SEL_LEN];
	logic [HEIGHT_W-1:0] quo;
	logic [HEIGHT_W-1:0] height_c;
	terrain_t            terrain_c;
	logic [MAX_OCTAVES:0]   one_sh;
	logic [MAX_OCTAVES-1:0] tot;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_seed_q     <= '0;
			base_frequency_q <= 24'd6554;
			octave_count_q   <= 4'd4;
			water_level_q    <= 17'd19661;
			grass_level_q    <= 17'd32768;
			forest_level_q   <= 17'd45875;
			peak_level_q     <= 17'd55706;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_SEED:   noise_seed_q     <= wr_data;
				CFG_FREQ:   base_frequency_q <= wr_data[FREQ_W-1:0];
				CFG_OCT:    octave_count_q   <= wr_data[3:0];
				CFG_WATER:  water_level_q    <= wr_data[HEIGHT_W-1:0];
				CFG_GRASS:  grass_level_q    <= wr_data[HEIGHT_W-1:0];
				CFG_FOREST: forest_level_q   <= wr_data[HEIGHT_W-1:0];
				CFG_PEAK:   peak_level_q     <= wr_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// saturated octave count and normalizing divisor (2^k - 1) * (2^24 - 1)
	assign one_sh = {{MAX_OCTAVES{1'b0}}, 1'b1} << k_q;
	assign tot    = MAX_OCTAVES'(one_sh - 1'b1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q   <= '0;
			den_q <= '0;
		end else begin
			k_q   <= ({1'b0, octave_count_q} > 5'(MAX_OCTAVES)) ?
				OCT_W'(MAX_OCTAVES) : OCT_W'(octave_count_q);
			den_q <= {tot, {HASH_W{1'b0}}} - SUM_W'(tot);
		end
	end

	// global advance
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= DIV_STG; s++) vld_s[s] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= s_tvalid;
			for (int s = 2; s <= DIV_STG; s++) vld_s[s] <= vld_s[s-1];
		end
	end

	// stage 1 coordinates, stage 2 scaled by base frequency
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= COORD_W'(s_tdata[COORD_W-1:0] % MAP_SIZE);
			y_s1  <= COORD_W'(s_tdata[2*COORD_W-1:COORD_W] % MAP_SIZE);
			xb_s2 <= XB_W'(x_s1) * XB_W'(base_frequency_q);
			yb_s2 <= XB_W'(y_s1) * XB_W'(base_frequency_q);
		end
	end

	// one lane per octave
	for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_lane
		vntc_lane #(.OCT(o)) u_lane (
			.clk(clk), .en(en), .seed(noise_seed_q),
			.xb(xb_s2), .yb(yb_s2), .n(lane_n[o])
		);
	end

	// Horner accumulation: acc = 2*acc + n_o for each active octave
	for (genvar j = 0; j < MAX_OCTAVES; j++) begin : g_acc
		logic [SUM_W-1:0]  acc_in;
		logic [HASH_W-1:0] n_in [MAX_OCTAVES];
		if (j == 0) begin : g_first
			assign acc_in = '0;
			assign n_in   = lane_n;
		end else begin : g_next
			assign acc_in = acc_s[j];
			assign n_in   = nrow_s[j-1];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j+1] <= (OCT_W'(j) < k_q) ?
					((acc_in << 1) + SUM_W'(n_in[j])) : acc_in;
				nrow_s[j]  <= n_in;
			end
		end
	end

	// normalize
	vntc_div #(.SW(SUM_W)) u_div (
		.clk(clk), .en(en), .num(acc_s[MAX_OCTAVES]), .den(den_q), .quo(quo)
	);

	// desert/mountain selector hash at (2x+17, 2y+31), delayed to the divider output
	vntc_hash u_sel (
		.clk(clk), .en(en), .seed(noise_seed_q),
		.i({21'b0, x_s1, 1'b0} + 32'd17),
		.j({21'b0, y_s1, 1'b0} + 32'd31),
		.v(sel_v)
	);
	always_ff @(posedge clk) begin
		if (en) begin
			sel_s[0] <= sel_v[HASH_W-1];
			for (int s = 1; s < SEL_LEN; s++) sel_s[s] <= sel_s[s-1];
		end
	end

	// clamp and classify
	always_comb begin
		if (k_q == '0)
			height_c = '0;
		else if (quo > HEIGHT_ONE)
			height_c = HEIGHT_ONE;
		else
			height_c = quo;
		if (height_c < water_level_q)
			terrain_c = TERR_WATER;
		else if (height_c < grass_level_q)
			terrain_c = TERR_GRASS;
		else if (height_c < forest_level_q)
			terrain_c = TERR_FOREST;
		else if (height_c < peak_level_q)
			terrain_c = sel_s[SEL_LEN-1] ? TERR_MOUNTAIN : TERR_DESERT;
		else
			terrain_c = TERR_MOUNTAIN;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= vld_s[DIV_STG];
		end
	end
	always_ff @(posedge clk) begin
		if (en) m_tdata <= {4'b0, terrain_c, height_c};
	end

	// checks
	a_height_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[HEIGHT_W-1:0] <= HEIGHT_ONE)
		else $error("height above 1.0");
	a_zero_oct: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && k_q == '0 && $past(k_q) == '0) |-> m_tdata[HEIGHT_W-1:0] == '0)
		else $error("nonzero height with no octaves");
	a_water: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[HEIGHT_W-1:0] < water_level_q && $stable(water_level_q))
		|-> m_tdata[HEIGHT_W+2:HEIGHT_W] == TERR_WATER)
		else $error("water band misclassified");
	a_out_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(vld_s[DIV_STG]))
		else $error("output valid without pipeline item");

endmodule
